@@ src/sapu_pkg.sv @@
package sapu_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_VER, PH_RSV1, PH_HLEN, PH_DEV, PH_FAM, PH_TRN, PH_HASH,
    PH_FW, PH_UTC, PH_SEQ, PH_INT, PH_CNT, PH_RSV2, PH_TDEL, PH_SDEL,
    PH_FLG, PH_TSS, PH_FCNT, PH_FLEN, PH_FBYTE, PH_DONE
  } phase_e;

  // result kinds
  localparam logic [4:0] KIND_DEV_ID    = 5'd0;
  localparam logic [4:0] KIND_FAMILY    = 5'd1;
  localparam logic [4:0] KIND_TRANSPORT = 5'd2;
  localparam logic [4:0] KIND_HASH      = 5'd3;
  localparam logic [4:0] KIND_FIRMWARE  = 5'd4;
  localparam logic [4:0] KIND_UTC       = 5'd5;
  localparam logic [4:0] KIND_SEQUENCE  = 5'd6;
  localparam logic [4:0] KIND_INTERVAL  = 5'd7;
  localparam logic [4:0] KIND_SMP_COUNT = 5'd8;
  localparam logic [4:0] KIND_TIME_DEL  = 5'd9;
  localparam logic [4:0] KIND_SEQ_DEL   = 5'd10;
  localparam logic [4:0] KIND_FLAGS     = 5'd11;
  localparam logic [4:0] KIND_TS_SRC    = 5'd12;
  localparam logic [4:0] KIND_FRM_COUNT = 5'd13;
  localparam logic [4:0] KIND_FRM_LEN   = 5'd14;
  localparam logic [4:0] KIND_FRM_BYTE  = 5'd15;
  localparam logic [4:0] KIND_STATUS    = 5'd16;

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC     = 4'd1;
  localparam logic [3:0] ST_LEN       = 4'd2;
  localparam logic [3:0] ST_CRC       = 4'd3;
  localparam logic [3:0] ST_MAGIC     = 4'd4;
  localparam logic [3:0] ST_VERSION   = 4'd5;
  localparam logic [3:0] ST_HDR_LEN   = 4'd6;
  localparam logic [3:0] ST_VARUINT   = 4'd7;
  localparam logic [3:0] ST_EXTRA     = 4'd8;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [32:0] COUNT_MAX   = 33'h1FFFFFFFF;
  localparam logic [15:0] HDR_LEN     = 16'd98;
  localparam logic [7:0]  VERSION_ONE = 8'd1;

  typedef logic [7:0] tag_t [4];
  localparam tag_t TAG = '{8'h47, 8'h57, 8'h52, 8'h31};

  typedef struct packed {
    logic [4:0]  item_kind;
    logic [63:0] field_value;
    logic [15:0] byte_position;
    logic [15:0] sample_number;
    logic [7:0]  frame_number;
    logic [3:0]  status_code;
    logic        end_of_archive;
  } result_t;

endpackage

@@ src/sapu_in_if.sv @@
interface sapu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ src/sapu_out_if.sv @@
interface sapu_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  item_kind;
  logic [63:0] field_value;
  logic [15:0] byte_position;
  logic [15:0] sample_number;
  logic [7:0]  frame_number;
  logic [3:0]  status_code;
  logic        end_of_archive;

  modport source (output valid, output item_kind, output field_value,
                  output byte_position, output sample_number, output frame_number,
                  output status_code, output end_of_archive, input ready);
  modport sink   (input valid, input item_kind, input field_value,
                  input byte_position, input sample_number, input frame_number,
                  input status_code, input end_of_archive, output ready);
endinterface

@@ src/sample_archive_stream_parser_unit.sv @@
// Archive stream parser. Takes one archive byte per beat on in_i (last_byte
// flags the final byte) and gives tagged field results on out_o, followed by
// a final status result on the last byte. Field results are provisional: only
// the status (end_of_archive = 1) says whether the archive held up. The last
// eight bytes are the trailer, so a byte is parsed eight beats after it came in.
// Rate: one byte per clock while the result queue has room. Each beat parses,
// CRC-updates and counts the byte taken eight beats earlier; its results are
// registered into a four-entry queue on out_o. in_i.ready is low only while the
// queue holds three or more results, i.e. when out_o is stalled. After the
// status beat the parser is back in its reset state for the next archive.
module sample_archive_stream_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sapu_in_if.sink    in_i,
  sapu_out_if.source out_o
);
  import sapu_pkg::*;

  logic    beat;
  logic    fld_vld, st_vld;
  result_t fld, st;

  // result queue
  result_t    q_mem [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] push_n;

  assign in_i.ready = (cnt_q <= 3'd2);
  assign beat       = in_i.valid && in_i.ready;

  sapu_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .byte_i    (in_i.data_byte),
    .last_i    (in_i.last_byte),
    .fld_vld_o (fld_vld),
    .fld_o     (fld),
    .st_vld_o  (st_vld),
    .st_o      (st)
  );

  assign pop    = out_o.valid && out_o.ready;
  assign push_n = 2'(fld_vld) + 2'(st_vld);

  always_comb begin
    wr_d  = wr_q + push_n;
    rd_d  = rd_q + 2'(pop);
    cnt_d = cnt_q + 3'(push_n) - 3'(pop);
  end

  // field result first, status behind it
  always_ff @(posedge clk_i) begin
    if (fld_vld) q_mem[wr_q] <= fld;
    if (st_vld) q_mem[wr_q + 2'(fld_vld)] <= st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_o.valid          = (cnt_q != 3'd0);
  assign out_o.item_kind      = q_mem[rd_q].item_kind;
  assign out_o.field_value    = q_mem[rd_q].field_value;
  assign out_o.byte_position  = q_mem[rd_q].byte_position;
  assign out_o.sample_number  = q_mem[rd_q].sample_number;
  assign out_o.frame_number   = q_mem[rd_q].frame_number;
  assign out_o.status_code    = q_mem[rd_q].status_code;
  assign out_o.end_of_archive = q_mem[rd_q].end_of_archive;

endmodule

@@ src/sapu_core.sv @@
module sapu_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             fld_vld_o,
  output sapu_pkg::result_t fld_o,
  output logic             st_vld_o,
  output sapu_pkg::result_t st_o
);
  import sapu_pkg::*;

  logic [7:0]  dly_q [8];
  logic [7:0]  dly_d [8];
  logic [3:0]  fill_q, fill_d;
  logic [31:0] crc_q, crc_d;
  logic [32:0] cnt_q, cnt_d;
  phase_e      ph_q, ph_d;
  logic [15:0] fbc_q, fbc_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  vsh_q, vsh_d;
  logic [15:0] smpl_q, smpl_d;
  logic [7:0]  frml_q, frml_d;
  logic [15:0] pl_q, pl_d;
  logic [15:0] smpc_q, smpc_d;
  logic [7:0]  frmc_q, frmc_d;
  logic [3:0]  err_q, err_d;
  logic        fwe_q, fwe_d;

  always_comb begin
    logic [7:0]  old;
    logic [31:0] c;
    logic [63:0] acc_n;
    logic [63:0] acc_v;
    logic [5:0]  shamt;
    logic        go_en;
    phase_e      go_ph;
    logic        ef;
    logic        es;
    logic [31:0] tlen;
    logic [31:0] tcrc;
    logic [3:0]  st;

    dly_d  = dly_q;
    fill_d = fill_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    fbc_d  = fbc_q;
    acc_d  = acc_q;
    vsh_d  = vsh_q;
    smpl_d = smpl_q;
    frml_d = frml_q;
    pl_d   = pl_q;
    smpc_d = smpc_q;
    frmc_d = frmc_q;
    err_d  = err_q;
    fwe_d  = fwe_q;
    fld_vld_o = 1'b0;
    fld_o     = '0;
    st_vld_o  = 1'b0;
    st_o      = '0;
    old   = dly_q[0];
    c     = crc_q;
    acc_n = {acc_q[55:0], byte_i};
    shamt = 6'(vsh_q) * 6'd7;
    acc_v = acc_q | (64'({1'b0, byte_i[6:0]}) << shamt);
    go_en = 1'b0;
    go_ph = PH_DONE;
    ef    = 1'b0;
    es    = 1'b0;
    tlen  = '0;
    tcrc  = '0;
    st    = ST_OK;

    if (beat_i) begin
      if (fill_q[3]) begin
        for (int i = 0; i < 7; i++) dly_d[i] = dly_q[i+1];
        dly_d[7] = byte_i;

        // reflected CRC-32, one bit per step
        c = crc_q ^ {24'd0, old};
        for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        crc_d = c;
        if (cnt_q != COUNT_MAX) cnt_d = cnt_q + 33'd1;

        if (err_q == ST_OK) begin
          acc_n = {acc_q[55:0], old};
          acc_v = acc_q | (64'({1'b0, old[6:0]}) << shamt);
          unique case (ph_q)
            PH_MAGIC: begin
              if (old != TAG[fbc_q[1:0]]) err_d = ST_MAGIC;
              else begin
                fbc_d = fbc_q + 16'd1;
                if (fbc_q == 16'd3) begin go_en = 1'b1; go_ph = PH_VER; end
              end
            end
            PH_VER: begin
              if (old != VERSION_ONE) err_d = ST_VERSION;
              else begin go_en = 1'b1; go_ph = PH_RSV1; end
            end
            PH_RSV1: begin go_en = 1'b1; go_ph = PH_HLEN; end
            PH_HLEN: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd1) begin
                if (acc_n != 64'(HDR_LEN)) err_d = ST_HDR_LEN;
                else begin go_en = 1'b1; go_ph = PH_DEV; end
              end
            end
            PH_DEV: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_DEV_ID;
              fld_o.field_value = 64'(old);
              fld_o.byte_position = fbc_q;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd15) begin go_en = 1'b1; go_ph = PH_FAM; end
            end
            PH_FAM: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_FAMILY;
              fld_o.field_value = 64'(old);
              go_en = 1'b1; go_ph = PH_TRN;
            end
            PH_TRN: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_TRANSPORT;
              fld_o.field_value = 64'(old);
              go_en = 1'b1; go_ph = PH_HASH;
            end
            PH_HASH: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_HASH;
              fld_o.field_value = 64'(old);
              fld_o.byte_position = fbc_q;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd31) begin go_en = 1'b1; go_ph = PH_FW; end
            end
            PH_FW: begin
              if (!fwe_q) begin
                if (old == 8'd0) fwe_d = 1'b1;
                else begin
                  fld_vld_o = 1'b1;
                  fld_o.item_kind = KIND_FIRMWARE;
                  fld_o.field_value = 64'(old);
                  fld_o.byte_position = fbc_q;
                end
              end
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd15) begin go_en = 1'b1; go_ph = PH_UTC; end
            end
            PH_UTC, PH_SEQ: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd7) begin
                fld_vld_o = 1'b1;
                fld_o.item_kind = (ph_q == PH_UTC) ? KIND_UTC : KIND_SEQUENCE;
                fld_o.field_value = acc_n;
                go_en = 1'b1;
                go_ph = (ph_q == PH_UTC) ? PH_SEQ : PH_INT;
              end
            end
            PH_INT: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd3) begin
                fld_vld_o = 1'b1;
                fld_o.item_kind = KIND_INTERVAL;
                fld_o.field_value = acc_n;
                go_en = 1'b1; go_ph = PH_CNT;
              end
            end
            PH_CNT: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd1) begin
                smpl_d = acc_n[15:0];
                smpc_d = '0;
                fld_vld_o = 1'b1;
                fld_o.item_kind = KIND_SMP_COUNT;
                fld_o.field_value = acc_n;
                go_en = 1'b1; go_ph = PH_RSV2;
              end
            end
            PH_RSV2: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd1) begin
                go_en = 1'b1;
                go_ph = (smpl_q != 16'd0) ? PH_TDEL : PH_DONE;
              end
            end
            PH_TDEL, PH_SDEL: begin
              acc_d = acc_v;
              if (!old[7]) begin
                fld_vld_o = 1'b1;
                fld_o.item_kind = (ph_q == PH_TDEL) ? KIND_TIME_DEL : KIND_SEQ_DEL;
                fld_o.field_value = acc_v;
                fld_o.sample_number = smpc_q;
                go_en = 1'b1;
                go_ph = (ph_q == PH_TDEL) ? PH_SDEL : PH_FLG;
              end else if (vsh_q >= 4'd9) begin
                err_d = ST_VARUINT;
              end else begin
                vsh_d = vsh_q + 4'd1;
              end
            end
            PH_FLG: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd1) begin
                fld_vld_o = 1'b1;
                fld_o.item_kind = KIND_FLAGS;
                fld_o.field_value = acc_n;
                fld_o.sample_number = smpc_q;
                go_en = 1'b1; go_ph = PH_TSS;
              end
            end
            PH_TSS: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_TS_SRC;
              fld_o.field_value = 64'(old);
              fld_o.sample_number = smpc_q;
              go_en = 1'b1; go_ph = PH_FCNT;
            end
            PH_FCNT: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_FRM_COUNT;
              fld_o.field_value = 64'(old);
              fld_o.sample_number = smpc_q;
              frml_d = old;
              frmc_d = '0;
              if (old == 8'd0) es = 1'b1;
              else begin go_en = 1'b1; go_ph = PH_FLEN; end
            end
            PH_FLEN: begin
              acc_d = acc_n;
              fbc_d = fbc_q + 16'd1;
              if (fbc_q == 16'd1) begin
                fld_vld_o = 1'b1;
                fld_o.item_kind = KIND_FRM_LEN;
                fld_o.field_value = acc_n;
                fld_o.sample_number = smpc_q;
                fld_o.frame_number = frmc_q;
                pl_d = acc_n[15:0];
                if (acc_n[15:0] == 16'd0) ef = 1'b1;
                else begin go_en = 1'b1; go_ph = PH_FBYTE; end
              end
            end
            PH_FBYTE: begin
              fld_vld_o = 1'b1;
              fld_o.item_kind = KIND_FRM_BYTE;
              fld_o.field_value = 64'(old);
              fld_o.byte_position = fbc_q;
              fld_o.sample_number = smpc_q;
              fld_o.frame_number = frmc_q;
              fbc_d = fbc_q + 16'd1;
              pl_d = pl_q - 16'd1;
              if (pl_q == 16'd1) ef = 1'b1;
            end
            PH_DONE: err_d = ST_EXTRA;
            default: err_d = ST_EXTRA;
          endcase

          // frame end may close the sample, sample end picks the next phase
          if (ef) begin
            frmc_d = frmc_q + 8'd1;
            frml_d = frml_q - 8'd1;
            if (frml_q == 8'd1) es = 1'b1;
            else begin go_en = 1'b1; go_ph = PH_FLEN; end
          end
          if (es) begin
            smpc_d = smpc_q + 16'd1;
            smpl_d = smpl_q - 16'd1;
            go_en = 1'b1;
            go_ph = (smpl_q == 16'd1) ? PH_DONE : PH_TDEL;
          end
          if (go_en) begin
            ph_d  = go_ph;
            fbc_d = '0;
            acc_d = '0;
            vsh_d = '0;
          end
        end
      end else begin
        dly_d[fill_q[2:0]] = byte_i;
        fill_d = fill_q + 4'd1;
      end

      if (last_i) begin
        for (int k = 0; k < 4; k++) begin
          tlen = {tlen[23:0], dly_d[k]};
          tcrc = {tcrc[23:0], dly_d[k+4]};
        end
        if (!fill_d[3] || cnt_d < 33'(HDR_LEN))        st = ST_TRUNC;
        else if (cnt_d != {1'b0, tlen})                  st = ST_LEN;
        else if ((crc_d ^ CRC_INIT) != tcrc)             st = ST_CRC;
        else if (err_d != ST_OK)                         st = err_d;
        else if (ph_d != PH_DONE)                        st = ST_TRUNC;
        else                                             st = ST_OK;
        st_vld_o = 1'b1;
        st_o.item_kind = KIND_STATUS;
        st_o.field_value = 64'(cnt_d);
        st_o.status_code = st;
        st_o.end_of_archive = 1'b1;

        fill_d = '0;
        crc_d  = CRC_INIT;
        cnt_d  = '0;
        ph_d   = PH_MAGIC;
        fbc_d  = '0;
        acc_d  = '0;
        vsh_d  = '0;
        smpl_d = '0;
        frml_d = '0;
        pl_d   = '0;
        smpc_d = '0;
        frmc_d = '0;
        err_d  = ST_OK;
        fwe_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q <= dly_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      ph_q   <= PH_MAGIC;
      fbc_q  <= '0;
      acc_q  <= '0;
      vsh_q  <= '0;
      smpl_q <= '0;
      frml_q <= '0;
      pl_q   <= '0;
      smpc_q <= '0;
      frmc_q <= '0;
      err_q  <= ST_OK;
      fwe_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      ph_q   <= ph_d;
      fbc_q  <= fbc_d;
      acc_q  <= acc_d;
      vsh_q  <= vsh_d;
      smpl_q <= smpl_d;
      frml_q <= frml_d;
      pl_q   <= pl_d;
      smpc_q <= smpc_d;
      frmc_q <= frmc_d;
      err_q  <= err_d;
      fwe_q  <= fwe_d;
    end
  end

endmodule

@@ src/sapu_checker.sv @@
module sapu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  item_kind_i,
  input logic [63:0] field_value_i,
  input logic [3:0]  status_code_i,
  input logic        end_of_archive_i
);
  import sapu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(item_kind_i)
      && $stable(field_value_i) && $stable(status_code_i))
    else $error("stalled result beat changed");

  a_eoa_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (end_of_archive_i == (item_kind_i == KIND_STATUS)))
    else $error("end_of_archive not tied to status kind");

  a_field_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !end_of_archive_i |-> status_code_i == ST_OK)
    else $error("field result carries a status code");

  a_status_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_of_archive_i && status_code_i != ST_TRUNC
      |-> field_value_i >= 64'(HDR_LEN))
    else $error("status on short archive not truncated");

endmodule

bind sample_archive_stream_parser_unit sapu_checker u_sapu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .item_kind_i      (out_o.item_kind),
  .field_value_i    (out_o.field_value),
  .status_code_i    (out_o.status_code),
  .end_of_archive_i (out_o.end_of_archive)
);

@@ tb/sv/sapu_result_checker.sv @@
`timescale 1ns / 1ps

module sapu_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sapu_in_if   in_mon,
  sapu_out_if  out_mon,
  output int   errors_o,
  output int   pending_o
);
  import sapu_pkg::*;

  logic [7:0]  hold_bytes [8];
  int unsigned hold_cnt;
  logic [31:0] crc;
  logic [32:0] nbytes;
  phase_e      ph;
  logic [15:0] fcnt;
  logic [63:0] acc;
  logic [3:0]  vshift;
  logic [15:0] smp_left;
  logic [7:0]  frm_left;
  logic [15:0] pay_left;
  logic [15:0] smp_idx;
  logic [7:0]  frm_idx;
  logic [3:0]  err;
  bit          fw_end;
  result_t     expected_q[$];

  function automatic void next_field(phase_e p);
    ph = p;
    fcnt = '0;
    acc = '0;
    vshift = '0;
  endfunction

  function automatic void clear_archive();
    hold_cnt = 0;
    crc = CRC_INIT;
    nbytes = '0;
    smp_left = '0;
    frm_left = '0;
    pay_left = '0;
    smp_idx = '0;
    frm_idx = '0;
    err = ST_OK;
    fw_end = 1'b0;
    next_field(PH_MAGIC);
  endfunction

  // big-endian gather, true once n bytes are in
  function automatic bit shift_in(logic [7:0] b, int n);
    acc = {acc[55:0], b};
    fcnt++;
    return fcnt >= n;
  endfunction

  function automatic void close_sample();
    smp_idx++;
    smp_left--;
    next_field(smp_left != 0 ? PH_TDEL : PH_DONE);
  endfunction

  function automatic void close_frame();
    frm_idx++;
    frm_left--;
    if (frm_left == 0) close_sample();
    else next_field(PH_FLEN);
  endfunction

  function automatic void queue_result(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void emit(logic [4:0] kind, logic [63:0] val, logic [15:0] pos,
                               logic [15:0] smp, logic [7:0] frm);
    result_t r;
    r = '{kind, val, pos, smp, frm, ST_OK, 1'b0};
    queue_result(r);
  endfunction

  function automatic void parse_body(logic [7:0] b);
    crc = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
    if (nbytes < COUNT_MAX) nbytes++;
    if (err != ST_OK) return;
    case (ph)
      PH_MAGIC: begin
        if (b != TAG[fcnt[1:0]]) err = ST_MAGIC;
        else begin
          fcnt++;
          if (fcnt >= 4) next_field(PH_VER);
        end
      end
      PH_VER: begin
        if (b != VERSION_ONE) err = ST_VERSION;
        else next_field(PH_RSV1);
      end
      PH_RSV1: next_field(PH_HLEN);
      PH_HLEN: begin
        if (shift_in(b, 2)) begin
          if (acc != 64'(HDR_LEN)) err = ST_HDR_LEN;
          else next_field(PH_DEV);
        end
      end
      PH_DEV: begin
        emit(KIND_DEV_ID, 64'(b), fcnt, 16'd0, 8'd0);
        fcnt++;
        if (fcnt >= 16) next_field(PH_FAM);
      end
      PH_FAM: begin
        emit(KIND_FAMILY, 64'(b), 16'd0, 16'd0, 8'd0);
        next_field(PH_TRN);
      end
      PH_TRN: begin
        emit(KIND_TRANSPORT, 64'(b), 16'd0, 16'd0, 8'd0);
        next_field(PH_HASH);
      end
      PH_HASH: begin
        emit(KIND_HASH, 64'(b), fcnt, 16'd0, 8'd0);
        fcnt++;
        if (fcnt >= 32) next_field(PH_FW);
      end
      PH_FW: begin
        // firmware string ends at its first zero byte
        if (!fw_end) begin
          if (b == 8'd0) fw_end = 1'b1;
          else emit(KIND_FIRMWARE, 64'(b), fcnt, 16'd0, 8'd0);
        end
        fcnt++;
        if (fcnt >= 16) next_field(PH_UTC);
      end
      PH_UTC, PH_SEQ: begin
        if (shift_in(b, 8)) begin
          emit(ph == PH_UTC ? KIND_UTC : KIND_SEQUENCE, acc, 16'd0, 16'd0, 8'd0);
          next_field(ph == PH_UTC ? PH_SEQ : PH_INT);
        end
      end
      PH_INT: begin
        if (shift_in(b, 4)) begin
          emit(KIND_INTERVAL, acc, 16'd0, 16'd0, 8'd0);
          next_field(PH_CNT);
        end
      end
      PH_CNT: begin
        if (shift_in(b, 2)) begin
          smp_left = acc[15:0];
          smp_idx = '0;
          emit(KIND_SMP_COUNT, acc, 16'd0, 16'd0, 8'd0);
          next_field(PH_RSV2);
        end
      end
      PH_RSV2: begin
        if (shift_in(b, 2)) next_field(smp_left != 0 ? PH_TDEL : PH_DONE);
      end
      PH_TDEL, PH_SDEL: begin
        acc = acc | ({57'd0, b[6:0]} << (7 * vshift));
        if (!b[7]) begin
          emit(ph == PH_TDEL ? KIND_TIME_DEL : KIND_SEQ_DEL, acc, 16'd0, smp_idx, 8'd0);
          next_field(ph == PH_TDEL ? PH_SDEL : PH_FLG);
        end else if (vshift >= 9) begin
          err = ST_VARUINT;
        end else begin
          vshift++;
        end
      end
      PH_FLG: begin
        if (shift_in(b, 2)) begin
          emit(KIND_FLAGS, acc, 16'd0, smp_idx, 8'd0);
          next_field(PH_TSS);
        end
      end
      PH_TSS: begin
        emit(KIND_TS_SRC, 64'(b), 16'd0, smp_idx, 8'd0);
        next_field(PH_FCNT);
      end
      PH_FCNT: begin
        emit(KIND_FRM_COUNT, 64'(b), 16'd0, smp_idx, 8'd0);
        frm_left = b;
        frm_idx = '0;
        if (b == 8'd0) close_sample();
        else next_field(PH_FLEN);
      end
      PH_FLEN: begin
        if (shift_in(b, 2)) begin
          emit(KIND_FRM_LEN, acc, 16'd0, smp_idx, frm_idx);
          pay_left = acc[15:0];
          if (pay_left == 0) close_frame();
          else next_field(PH_FBYTE);
        end
      end
      PH_FBYTE: begin
        emit(KIND_FRM_BYTE, 64'(b), fcnt, smp_idx, frm_idx);
        fcnt++;
        pay_left--;
        if (pay_left == 0) close_frame();
      end
      default: err = ST_EXTRA;
    endcase
  endfunction

  function automatic void take_beat(logic [7:0] b, logic last);
    result_t r;
    logic [31:0] tlen;
    logic [31:0] tcrc;
    logic [3:0] st;
    if (hold_cnt >= 8) begin
      logic [7:0] oldest;
      oldest = hold_bytes[0];
      for (int k = 0; k < 7; k++) hold_bytes[k] = hold_bytes[k + 1];
      hold_bytes[7] = b;
      parse_body(oldest);
    end else begin
      hold_bytes[hold_cnt] = b;
      hold_cnt++;
    end
    if (!last) return;
    if (hold_cnt < 8 || nbytes < 33'(HDR_LEN)) begin
      st = ST_TRUNC;
    end else begin
      tlen = {hold_bytes[0], hold_bytes[1], hold_bytes[2], hold_bytes[3]};
      tcrc = {hold_bytes[4], hold_bytes[5], hold_bytes[6], hold_bytes[7]};
      if (nbytes != {1'b0, tlen}) st = ST_LEN;
      else if ((crc ^ CRC_INIT) != tcrc) st = ST_CRC;
      else if (err != ST_OK) st = err;
      else if (ph != PH_DONE) st = ST_TRUNC;
      else st = ST_OK;
    end
    r = '{KIND_STATUS, {31'd0, nbytes}, 16'd0, 16'd0, 8'd0, st, 1'b1};
    queue_result(r);
    clear_archive();
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, e, a);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_archive();
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) take_beat(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, kind %0d value 0x%0h", $time,
                   out_mon.item_kind, out_mon.field_value);
          errors_o++;
        end else begin
          result_t e;
          e = expected_q.pop_front();
          check_field("item_kind", 64'(e.item_kind), 64'(out_mon.item_kind));
          check_field("field_value", e.field_value, out_mon.field_value);
          check_field("byte_position", 64'(e.byte_position), 64'(out_mon.byte_position));
          check_field("sample_number", 64'(e.sample_number), 64'(out_mon.sample_number));
          check_field("frame_number", 64'(e.frame_number), 64'(out_mon.frame_number));
          check_field("status_code", 64'(e.status_code), 64'(out_mon.status_code));
          check_field("end_of_archive", 64'(e.end_of_archive),
                      64'(out_mon.end_of_archive));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ tb/sv/sample_archive_stream_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module sample_archive_stream_parser_unit_tb;
  import sapu_pkg::*;

  // archive flavors for the random part; anything past BAD_HLEN is clean
  typedef enum int {
    BAD_CORRUPT, BAD_TRUNC, BAD_EXTRA, BAD_TLEN, BAD_TCRC, BAD_VARUINT,
    BAD_MAGIC, BAD_VERSION, BAD_HLEN, CLEAN
  } flavor_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sapu_in_if  in_if ();
  sapu_out_if out_if ();

  int errors;
  int pending;
  int idle_cnt = 0;
  int bytes_sent;
  bit no_idle;          // set for a stretch of archives with both sides busy

  logic [7:0] body_q[$];
  logic [7:0] arc_q[$];

  always #5 clk_i = ~clk_i;

  sample_archive_stream_parser_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  sapu_result_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // result side: random backpressure, ~12% stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  // watchdog: any cycle without a beat on either side counts toward the limit
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= 2000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // one beat on the byte channel, with optional idle cycles in front
  task automatic send_byte(logic [7:0] b, logic last);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_archive();
    foreach (arc_q[i]) send_byte(arc_q[i], i == arc_q.size() - 1);
    bytes_sent += arc_q.size();
  endtask

  task automatic put_body(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  task automatic put_arc(logic [7:0] b);
    arc_q.insert(arc_q.size(), b);
  endtask

  task automatic push_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) put_body(v[8*i +: 8]);
  endtask

  // 1..10 groups; a broken one keeps bit 7 set on the tenth group
  task automatic push_varuint(bit broken);
    int groups;
    logic [7:0] g;
    groups = broken ? 10 : $urandom_range(1, 10);
    if (!broken && $urandom_range(3) == 0) groups = 1;
    for (int i = 0; i < groups; i++) begin
      g = 8'($urandom_range(255));
      g[7] = (i < groups - 1) || broken;
      put_body(g);
    end
  endtask

  function automatic logic [31:0] body_crc();
    logic [31:0] c;
    c = CRC_INIT;
    foreach (body_q[i]) begin
      c = c ^ {24'd0, body_q[i]};
      for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c ^ CRC_INIT;
  endfunction

  task automatic build_archive(flavor_e fl);
    int nsmp;
    int nfrm;
    int plen;
    int bad_smp;
    logic [31:0] tlen;
    logic [31:0] tcrc;
    body_q.delete();
    arc_q.delete();
    for (int i = 0; i < 4; i++) put_body(TAG[i]);
    if (fl == BAD_MAGIC) body_q[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    put_body(fl == BAD_VERSION ? 8'($urandom_range(2, 255)) : VERSION_ONE);
    put_body(8'($urandom_range(255)));
    push_be(fl == BAD_HLEN ? 64'($urandom_range(0, 97)) : 64'(HDR_LEN), 2);
    repeat (18) put_body(8'($urandom_range(255)));  // device id, family, transport
    repeat (32) put_body(8'($urandom_range(255)));
    // firmware: nonzero bytes padded mostly with zeros, sometimes no terminator
    plen = $urandom_range(0, 16);
    for (int i = 0; i < 16; i++)
      put_body(i < plen ? 8'($urandom_range(1, 255)) :
               ($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'd0));
    push_be({$urandom, $urandom}, 8);
    push_be({$urandom, $urandom}, 8);
    push_be(64'($urandom), 4);
    nsmp = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
    push_be(64'(nsmp), 2);
    push_be(64'($urandom_range(65535)), 2);
    bad_smp = $urandom_range(0, nsmp > 0 ? nsmp - 1 : 0);
    for (int s = 0; s < nsmp; s++) begin
      push_varuint(fl == BAD_VARUINT && s == bad_smp);
      push_varuint(1'b0);
      push_be(64'($urandom_range(65535)), 2);
      put_body(8'($urandom_range(255)));
      nfrm = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 3);
      put_body(8'(nfrm));
      for (int f = 0; f < nfrm; f++) begin
        plen = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 6);
        push_be(64'(plen), 2);
        repeat (plen) put_body(8'($urandom_range(255)));
      end
    end
    if (fl == BAD_EXTRA) repeat ($urandom_range(1, 4)) put_body(8'($urandom_range(255)));
    if (fl == BAD_TRUNC) repeat ($urandom_range(1, body_q.size())) void'(body_q.pop_back());
    if (fl == BAD_CORRUPT) body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom_range(255));
    tlen = 32'(body_q.size());
    tcrc = body_crc();
    if (fl == BAD_TLEN) tlen ^= 32'(1 << $urandom_range(31));
    if (fl == BAD_TCRC) tcrc ^= 32'(1 << $urandom_range(31));
    arc_q = body_q;
    for (int i = 3; i >= 0; i--) put_arc(tlen[8*i +: 8]);
    for (int i = 3; i >= 0; i--) put_arc(tcrc[8*i +: 8]);
  endtask

  initial begin
    int archives;
    int pick;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'd0;
    in_if.last_byte <= 1'b0;
    bytes_sent = 0;
    no_idle    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: archives too short to hold a trailer, one with only a trailer, one with a byte ahead of it
    arc_q = '{8'hFF};
    send_archive();
    arc_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_archive();
    arc_q = '{8'h47, 8'h57, 8'h52, 8'h31, 8'h01, 8'h00, 8'h00, 8'hFF};
    send_archive();
    arc_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hA5, 8'hFF, 8'h00, 8'h80, 8'h7F};
    send_archive();

    // every flavor once, then random mix weighted toward clean archives
    archives = 0;
    while (archives <= CLEAN || bytes_sent < 1000) begin
      no_idle = (archives == 2 || archives == 3);
      if (archives == 5) begin
        // hold off until every expected result is out
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (archives <= CLEAN) begin
        build_archive(flavor_e'(archives));
      end else begin
        pick = $urandom_range(0, 17);
        build_archive(pick > CLEAN ? CLEAN : flavor_e'(pick));
      end
      send_archive();
      archives++;
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
